### rtl/core/sib_pkg.sv
package sib_pkg;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_DX,
      ST_PUSH_DY,
      ST_PUSH_TH,
      ST_PUSH_CMP,
      ST_Q_RD,
      ST_Q_CHK,
      ST_Q_MUL,
      ST_Q_DIVINIT,
      ST_Q_DIV,
      ST_Q_ADD,
      ST_Q_EMIT
   } state_type;

   // Beat kinds on the request channel
   localparam logic KIND_PUSH  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Source codes on the response channel
   localparam logic [2:0] SRC_FALLBACK = 3'd0;
   localparam logic [2:0] SRC_SINGLE   = 3'd1;
   localparam logic [2:0] SRC_BEFORE   = 3'd2;
   localparam logic [2:0] SRC_AFTER    = 3'd3;
   localparam logic [2:0] SRC_INTERP   = 3'd4;

   // Ring entry is {time, y, x}
   localparam int ENTRY_W = 80;

   // Quotient bits of the interpolation divide: |q| < 2^24
   localparam int DIV_STEPS = 24;

   localparam logic [23:0] SNAP_THRESHOLD_RESET = 24'd25600;

endpackage

### rtl/core/sib_ram.sv
module sib_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/snapshot_interp_buffer.sv
// Sequencing: a push holds the request side through PUSH_DX, PUSH_DY, PUSH_TH and PUSH_CMP
//   from accept to the next accept. A query on an empty ring goes straight to emit; otherwise it
//   reads and checks the scanned entries in turn, then emits the entry it holds or interpolates
//   (per axis: multiply, divide setup, one divide step per quotient bit, add back).
// Throughput: one beat at a time; the request side stalls until the sequencer is idle, and a
//   result held by rsp_stall holds the sequencer. Reset: synchronous, active high; clears head,
//   count, last sample and response valid, loads the default snap threshold; no clearing pass.
module snapshot_interp_buffer #(
   parameter int RING_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   input  logic        [31:0] req_time_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_out_x,
   output logic signed [23:0] rsp_out_y,
   output logic        [2:0]  rsp_source,
   // configuration
   input  logic               csr_we,
   input  logic        [23:0] csr_wdata
);

   localparam int AW  = $clog2(RING_DEPTH);
   localparam int CW  = $clog2(RING_DEPTH + 1);
   localparam int SW  = CW + 1;
   localparam int DCW = $clog2(sib_pkg::DIV_STEPS);

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   sib_pkg::state_type state_ff, state_in;

   logic        [23:0] threshold_ff, threshold_in;
   logic      [AW-1:0] write_head_ff, write_head_in;
   logic      [CW-1:0] fill_ff, fill_in;
   logic signed [23:0] last_x_ff, last_x_in;
   logic signed [23:0] last_y_ff, last_y_in;
   logic               have_last_ff, have_last_in;

   // latched request beat
   logic signed [23:0] in_x_ff, in_x_in;
   logic signed [23:0] in_y_ff, in_y_in;
   logic        [31:0] in_t_ff, in_t_in;

   // shared multiplier and accumulator
   logic signed [24:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [57:0] prod_ff, prod_in;
   logic        [49:0] acc_ff, acc_in;

   // scan
   logic      [AW-1:0] scan_addr_ff, scan_addr_in;
   logic      [AW-1:0] k_ff, k_in;
   logic               single_ff, single_in;
   logic signed [23:0] x0_ff, x0_in, y0_ff, y0_in;
   logic signed [23:0] x1_ff, x1_in, y1_ff, y1_in;
   logic        [31:0] t0_ff, t0_in, t1_ff, t1_in;
   logic               coord_ff, coord_in;

   // divider
   logic        [31:0] span_ff, span_in;
   logic        [31:0] rem_ff, rem_in;
   logic        [23:0] dvd_ff, dvd_in;
   logic        [23:0] quo_ff, quo_in;
   logic               neg_ff, neg_in;
   logic     [DCW-1:0] cnt_ff, cnt_in;

   // result staging and response register
   logic signed [23:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic         [2:0] res_src_ff, res_src_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic         [2:0] rsp_src_ff, rsp_src_in;

   // ring memory
   logic                          ram_we;
   logic [AW-1:0]                 ram_waddr;
   logic [sib_pkg::ENTRY_W-1:0]   ram_rdata;
   logic signed [23:0]            e_x, e_y;
   logic        [31:0]            e_t;

   sib_ram #(
      .WIDTH (sib_pkg::ENTRY_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({in_t_ff, in_y_ff, in_x_ff}),
      .rd_addr (scan_addr_ff),
      .rd_data (ram_rdata)
   );

   assign e_x = ram_rdata[23:0];
   assign e_y = ram_rdata[47:24];
   assign e_t = ram_rdata[79:48];

   // Step one place forward around the ring.
   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] a);
      logic [AW-1:0] r;
      if (a == AW'(RING_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = a + AW'(1);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Datapath pieces shared by the sequencer
   // ------------------------------------------------------------------
   logic signed [24:0] push_dx, push_dy, lerp_dx, lerp_dy;
   logic        [31:0] lerp_num;
   logic      [AW-1:0] newest_addr, oldest_addr;
   logic      [SW-1:0] oldest_sum;
   logic        [57:0] prod_mag;
   logic        [32:0] div_top, div_diff;
   logic               div_ge;
   logic        [23:0] quo_next;
   logic signed [24:0] q_signed, p0_wide, lerp_sum;

   assign push_dx  = 25'(in_x_ff) - 25'(last_x_ff);
   assign push_dy  = 25'(in_y_ff) - 25'(last_y_ff);
   assign lerp_dx  = 25'(x1_ff) - 25'(x0_ff);
   assign lerp_dy  = 25'(y1_ff) - 25'(y0_ff);
   assign lerp_num = in_t_ff - t0_ff;

   // The single multiplier; its product is registered every cycle.
   assign prod_in = 58'(mul_a) * 58'(mul_b);

   // Newest entry sits just behind the write head, oldest fill places behind it.
   assign newest_addr = (write_head_ff == '0) ? AW'(RING_DEPTH - 1)
                                              : write_head_ff - AW'(1);
   assign oldest_sum  = SW'(write_head_ff) + SW'(RING_DEPTH) - SW'(fill_ff);
   assign oldest_addr = (oldest_sum >= SW'(RING_DEPTH))
                        ? AW'(oldest_sum - SW'(RING_DEPTH)) : AW'(oldest_sum);

   // Restoring divide on magnitudes, one quotient bit per cycle. Since the
   // quotient stays below 2^24, the upper product bits already sit below span.
   assign prod_mag = prod_ff[57] ? 58'(-prod_ff) : prod_ff;
   assign div_top  = {rem_ff, dvd_ff[23]};
   assign div_diff = div_top - {1'b0, span_ff};
   assign div_ge   = (div_top >= {1'b0, span_ff});
   assign quo_next = {quo_ff[22:0], div_ge};

   // Apply the sign and add back the start point.
   assign q_signed = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign p0_wide  = coord_ff ? 25'(y0_ff) : 25'(x0_ff);
   assign lerp_sum = p0_wide + q_signed;

   // ------------------------------------------------------------------
   // Sequencer: next state and datapath controls
   // ------------------------------------------------------------------
   always_comb begin
      logic snap;

      state_in      = state_ff;
      threshold_in  = threshold_ff;
      write_head_in = write_head_ff;
      fill_in       = fill_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      have_last_in  = have_last_ff;
      in_x_in       = in_x_ff;
      in_y_in       = in_y_ff;
      in_t_in       = in_t_ff;
      acc_in        = acc_ff;
      scan_addr_in  = scan_addr_ff;
      k_in          = k_ff;
      single_in     = single_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      t0_in         = t0_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      t1_in         = t1_ff;
      coord_in      = coord_ff;
      span_in       = span_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      quo_in        = quo_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_src_in    = res_src_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_src_in    = rsp_src_ff;
      mul_a         = '0;
      mul_b         = '0;
      ram_we        = 1'b0;
      ram_waddr     = write_head_ff;
      snap          = 1'b0;

      if (csr_we) begin
         threshold_in = csr_wdata;
      end

      // drop the response once it is taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sib_pkg::ST_IDLE: begin
            if (req_valid) begin
               in_x_in  = req_pos_x;
               in_y_in  = req_pos_y;
               in_t_in  = req_time_value;
               coord_in = 1'b0;
               k_in     = '0;
               if (req_kind == sib_pkg::KIND_PUSH) begin
                  state_in = sib_pkg::ST_PUSH_DX;
               end else if (fill_ff == '0) begin
                  res_x_in   = req_pos_x;
                  res_y_in   = req_pos_y;
                  res_src_in = sib_pkg::SRC_FALLBACK;
                  state_in   = sib_pkg::ST_Q_EMIT;
               end else begin
                  single_in    = (fill_ff == CW'(1));
                  scan_addr_in = (fill_ff == CW'(1)) ? newest_addr : oldest_addr;
                  state_in     = sib_pkg::ST_Q_RD;
               end
            end
         end

         sib_pkg::ST_PUSH_DX: begin
            mul_a    = push_dx;
            mul_b    = 33'(push_dx);
            state_in = sib_pkg::ST_PUSH_DY;
         end

         sib_pkg::ST_PUSH_DY: begin
            mul_a    = push_dy;
            mul_b    = 33'(push_dy);
            acc_in   = prod_ff[49:0];
            state_in = sib_pkg::ST_PUSH_TH;
         end

         sib_pkg::ST_PUSH_TH: begin
            mul_a    = {1'b0, threshold_ff};
            mul_b    = {9'd0, threshold_ff};
            acc_in   = acc_ff + prod_ff[49:0];
            state_in = sib_pkg::ST_PUSH_CMP;
         end

         sib_pkg::ST_PUSH_CMP: begin
            // a jump strictly beyond the threshold empties the ring first
            snap          = have_last_ff && (acc_ff > prod_ff[49:0]);
            ram_waddr     = snap ? '0 : write_head_ff;
            ram_we        = 1'b1;
            write_head_in = ring_next(ram_waddr);
            if (snap) begin
               fill_in = CW'(1);
            end else if (fill_ff < CW'(RING_DEPTH)) begin
               fill_in = fill_ff + CW'(1);
            end
            last_x_in    = in_x_ff;
            last_y_in    = in_y_ff;
            have_last_in = 1'b1;
            state_in     = sib_pkg::ST_IDLE;
         end

         sib_pkg::ST_Q_RD: begin
            state_in = sib_pkg::ST_Q_CHK;
         end

         sib_pkg::ST_Q_CHK: begin
            if (single_ff) begin
               res_x_in   = e_x;
               res_y_in   = e_y;
               res_src_in = sib_pkg::SRC_SINGLE;
               state_in   = sib_pkg::ST_Q_EMIT;
            end else if (e_t <= in_t_ff) begin
               x0_in = e_x;
               y0_in = e_y;
               t0_in = e_t;
               if (CW'(k_ff) == fill_ff - CW'(1)) begin
                  // render time is at or past the newest entry
                  res_x_in   = e_x;
                  res_y_in   = e_y;
                  res_src_in = sib_pkg::SRC_AFTER;
                  state_in   = sib_pkg::ST_Q_EMIT;
               end else begin
                  k_in         = k_ff + AW'(1);
                  scan_addr_in = ring_next(scan_addr_ff);
                  state_in     = sib_pkg::ST_Q_RD;
               end
            end else if (k_ff == '0) begin
               // render time is before the oldest entry
               res_x_in   = e_x;
               res_y_in   = e_y;
               res_src_in = sib_pkg::SRC_BEFORE;
               state_in   = sib_pkg::ST_Q_EMIT;
            end else begin
               x1_in    = e_x;
               y1_in    = e_y;
               t1_in    = e_t;
               state_in = sib_pkg::ST_Q_MUL;
            end
         end

         sib_pkg::ST_Q_MUL: begin
            mul_a   = coord_ff ? lerp_dy : lerp_dx;
            mul_b   = {1'b0, lerp_num};
            span_in = t1_ff - t0_ff;
            if (t1_ff == t0_ff) begin
               res_x_in   = x1_ff;
               res_y_in   = y1_ff;
               res_src_in = sib_pkg::SRC_INTERP;
               state_in   = sib_pkg::ST_Q_EMIT;
            end else begin
               state_in = sib_pkg::ST_Q_DIVINIT;
            end
         end

         sib_pkg::ST_Q_DIVINIT: begin
            neg_in   = prod_ff[57];
            rem_in   = prod_mag[55:24];
            dvd_in   = prod_mag[23:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = sib_pkg::ST_Q_DIV;
         end

         sib_pkg::ST_Q_DIV: begin
            rem_in = div_ge ? div_diff[31:0] : div_top[31:0];
            dvd_in = {dvd_ff[22:0], 1'b0};
            quo_in = quo_next;
            cnt_in = cnt_ff + DCW'(1);
            if (cnt_ff == DCW'(sib_pkg::DIV_STEPS - 1)) begin
               state_in = sib_pkg::ST_Q_ADD;
            end
         end

         sib_pkg::ST_Q_ADD: begin
            if (coord_ff) begin
               res_y_in   = lerp_sum[23:0];
               res_src_in = sib_pkg::SRC_INTERP;
               state_in   = sib_pkg::ST_Q_EMIT;
            end else begin
               res_x_in = lerp_sum[23:0];
               coord_in = 1'b1;
               state_in = sib_pkg::ST_Q_MUL;
            end
         end

         sib_pkg::ST_Q_EMIT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_src_in   = res_src_ff;
               state_in     = sib_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sib_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sib_pkg::ST_IDLE;
         threshold_ff  <= sib_pkg::SNAP_THRESHOLD_RESET;
         write_head_ff <= '0;
         fill_ff       <= '0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         have_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         threshold_ff  <= threshold_in;
         write_head_ff <= write_head_in;
         fill_ff       <= fill_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
         have_last_ff  <= have_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_x_ff      <= in_x_in;
      in_y_ff      <= in_y_in;
      in_t_ff      <= in_t_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      scan_addr_ff <= scan_addr_in;
      k_ff         <= k_in;
      single_ff    <= single_in;
      x0_ff        <= x0_in;
      y0_ff        <= y0_in;
      t0_ff        <= t0_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      t1_ff        <= t1_in;
      coord_ff     <= coord_in;
      span_ff      <= span_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      quo_ff       <= quo_in;
      neg_ff       <= neg_in;
      cnt_ff       <= cnt_in;
      res_x_ff     <= res_x_in;
      res_y_ff     <= res_y_in;
      res_src_ff   <= res_src_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_src_ff   <= rsp_src_in;
   end

   // ------------------------------------------------------------------
   // Ports
   // ------------------------------------------------------------------
   assign req_stall  = (state_ff != sib_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = rsp_x_ff;
   assign rsp_out_y  = rsp_y_ff;
   assign rsp_source = rsp_src_ff;

`ifndef ASSERT_OFF
   // Until the ring wraps, the head and the count advance together.
   a_head_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != CW'(RING_DEPTH)) |-> (fill_ff == CW'(write_head_ff)))
      else $error("write head and fill count out of step");

   // The count never passes the ring depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(RING_DEPTH))
      else $error("fill count beyond ring depth");

   // A response appears only after the emit step.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == sib_pkg::ST_Q_EMIT))
      else $error("response raised outside emit");

   // The partial remainder stays below the divisor through the divide.
   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sib_pkg::ST_Q_DIV) |-> (rem_ff < span_ff))
      else $error("divider remainder not below span");
`endif

endmodule
